// File: hdl/fmsp_pkg.sv
package fmsp_pkg;

    typedef enum logic [1:0] {
        PH_WHO,
        PH_PERM,
        PH_ERR,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_SET
    } op_t;

    localparam logic [8:0] ALL_BITS = 9'o777;
    localparam logic [9:0] OCT_SAT  = 10'd512;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic [8:0] start_mode;
    } req_t;

    typedef struct packed {
        logic [8:0] new_mode;
        logic       status;
    } rsp_t;

    typedef struct packed {
        logic       hit;
        logic [8:0] bits;
    } perm_t;

    function automatic op_t op_code(input logic [7:0] c);
        op_t r;
        case (c)
            CH_PLUS:  r = OP_ADD;
            CH_MINUS: r = OP_SUB;
            CH_EQ:    r = OP_SET;
            default:  r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] who_bits(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_A:    r = ALL_BITS;
            CH_U:    r = 9'o700;
            CH_G:    r = 9'o070;
            CH_O:    r = 9'o007;
            default: r = 9'o000;
        endcase
        return r;
    endfunction

    function automatic perm_t perm_bits(input logic [7:0] c, input logic [8:0] mode);
        perm_t r;
        r.hit = 1'b1;
        case (c)
            CH_R:    r.bits = 9'o444;
            CH_W:    r.bits = 9'o222;
            CH_X:    r.bits = 9'o111;
            CH_U:    r.bits = {3{mode[8:6]}};
            CH_G:    r.bits = {3{mode[5:3]}};
            CH_O:    r.bits = {3{mode[2:0]}};
            default:
            begin
                r.hit  = 1'b0;
                r.bits = 9'o000;
            end
        endcase
        return r;
    endfunction

    function automatic logic [8:0] apply_clause(input logic [8:0] mode, input logic [8:0] who,
                                                input logic [8:0] perm, input op_t op);
        logic [8:0] sel;
        logic [8:0] r;
        sel = perm & who;
        case (op)
            OP_ADD:  r = mode | sel;
            OP_SUB:  r = mode & ~sel;
            OP_SET:  r = (mode & ~who) | sel;
            default: r = mode;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/file_mode_string_parser.sv
// channel | signals                          | moves
// --------+----------------------------------+-------------------------------------
// ch      | ch_valid, ch_stall, ch_data      | one character, first flag, start mode
// mode    | mode_valid, mode_stall, mode_data| new mode and status, on nul only
//
// one character per cycle while ch_stall is low; a request is held in the input register,
// and its result (if any) is then written to the output register
// rst_n clears the parser to a new string with starting mode 0
// ch_stall rises only when a nul waits for a full, stalled output register
module file_mode_string_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ch_valid,
    output logic                ch_stall,
    input  fmsp_pkg::req_t      ch_data,
    output logic                mode_valid,
    input  logic                mode_stall,
    output fmsp_pkg::rsp_t      mode_data
);

    logic                in_valid_reg;
    fmsp_pkg::req_t      in_reg;
    logic                out_valid_reg;
    fmsp_pkg::rsp_t      out_reg;

    logic [8:0]          cur_mode_reg, cur_mode_next;
    logic [8:0]          who_mask_reg, who_mask_next;
    logic [8:0]          perm_mask_reg, perm_mask_next;
    fmsp_pkg::op_t       op_kind_reg, op_kind_next;
    fmsp_pkg::phase_t    phase_reg, phase_next;
    logic [9:0]          octal_value_reg, octal_value_next;
    logic                octal_ok_reg, octal_ok_next;
    logic                octal_neg_reg, octal_neg_next;
    logic                err_flag_reg, err_flag_next;
    logic                at_start_reg, at_start_next;
    logic                octal_digits_reg, octal_digits_next;

    logic [8:0]          s_cur, s_who, s_perm;
    fmsp_pkg::op_t       s_op;
    fmsp_pkg::phase_t    s_phase;
    logic [9:0]          s_oct;
    logic                s_ok, s_neg, s_err, s_start, s_digits;

    logic [7:0]          ch;
    logic                active, is_nul, emit, advance;
    logic [8:0]          w_bits;
    fmsp_pkg::op_t       op_c;
    fmsp_pkg::perm_t     pm;
    logic [11:0]         oct_tmp;
    logic                bad_oct;
    fmsp_pkg::rsp_t      result;

    // state as seen by this character, after an optional new-string start
    always_comb
    begin
        if (in_reg.first)
        begin
            s_cur    = in_reg.start_mode;
            s_who    = 9'o000;
            s_perm   = 9'o000;
            s_op     = fmsp_pkg::OP_NONE;
            s_phase  = fmsp_pkg::PH_WHO;
            s_oct    = 10'd0;
            s_ok     = 1'b1;
            s_neg    = 1'b0;
            s_err    = 1'b0;
            s_start  = 1'b1;
            s_digits = 1'b0;
        end
        else
        begin
            s_cur    = cur_mode_reg;
            s_who    = who_mask_reg;
            s_perm   = perm_mask_reg;
            s_op     = op_kind_reg;
            s_phase  = phase_reg;
            s_oct    = octal_value_reg;
            s_ok     = octal_ok_reg;
            s_neg    = octal_neg_reg;
            s_err    = err_flag_reg;
            s_start  = at_start_reg;
            s_digits = octal_digits_reg;
        end
    end

    assign ch      = in_reg.ch;
    assign active  = in_valid_reg && (s_phase != fmsp_pkg::PH_DONE);
    assign is_nul  = (ch == fmsp_pkg::CH_NUL);
    assign emit    = active && is_nul;
    assign advance = in_valid_reg && !(emit && out_valid_reg && mode_stall);
    assign ch_stall = in_valid_reg && !advance;

    assign w_bits  = fmsp_pkg::who_bits(ch);
    assign op_c    = fmsp_pkg::op_code(ch);
    assign pm      = fmsp_pkg::perm_bits(ch, s_cur);
    assign oct_tmp = {s_oct[8:0], 3'b000} + {9'd0, ch[2:0]};

    // next state
    always_comb
    begin
        phase_next = s_phase;
        if (active)
        begin
            case (s_phase)
                fmsp_pkg::PH_WHO:
                begin
                    if (w_bits == 9'o000)
                    begin
                        phase_next = (op_c != fmsp_pkg::OP_NONE) ? fmsp_pkg::PH_PERM
                                                                 : fmsp_pkg::PH_ERR;
                    end
                end
                fmsp_pkg::PH_PERM:
                begin
                    if (!pm.hit)
                    begin
                        if (ch == fmsp_pkg::CH_COMMA)
                        begin
                            phase_next = fmsp_pkg::PH_WHO;
                        end
                        else if (op_c == fmsp_pkg::OP_NONE && !is_nul)
                        begin
                            phase_next = fmsp_pkg::PH_ERR;
                        end
                    end
                end
                default:
                begin
                    phase_next = s_phase;
                end
            endcase
            if (is_nul)
            begin
                phase_next = fmsp_pkg::PH_DONE;
            end
        end
    end

    // datapath
    always_comb
    begin
        cur_mode_next     = s_cur;
        who_mask_next     = s_who;
        perm_mask_next    = s_perm;
        op_kind_next      = s_op;
        octal_value_next  = s_oct;
        octal_ok_next     = s_ok;
        octal_neg_next    = s_neg;
        err_flag_next     = s_err;
        at_start_next     = s_start;
        octal_digits_next = s_digits;
        bad_oct           = 1'b0;
        result.new_mode   = 9'o000;
        result.status     = 1'b0;
        if (active)
        begin
            if (!is_nul)
            begin
                if (ch >= fmsp_pkg::CH_ZERO && ch <= fmsp_pkg::CH_SEVEN)
                begin
                    if (s_oct < fmsp_pkg::OCT_SAT)
                    begin
                        octal_value_next = (oct_tmp > {3'b000, fmsp_pkg::ALL_BITS})
                                           ? fmsp_pkg::OCT_SAT : oct_tmp[9:0];
                    end
                    octal_digits_next = 1'b1;
                end
                else if (s_start && (ch == fmsp_pkg::CH_PLUS || ch == fmsp_pkg::CH_MINUS))
                begin
                    octal_neg_next = (ch == fmsp_pkg::CH_MINUS);
                end
                else
                begin
                    octal_ok_next = 1'b0;
                end
            end
            case (s_phase)
                fmsp_pkg::PH_WHO:
                begin
                    if (w_bits != 9'o000)
                    begin
                        who_mask_next = s_who | w_bits;
                    end
                    else
                    begin
                        if (s_who == 9'o000)
                        begin
                            who_mask_next = fmsp_pkg::ALL_BITS;
                        end
                        op_kind_next = op_c;
                        if (op_c != fmsp_pkg::OP_NONE)
                        begin
                            perm_mask_next = 9'o000;
                        end
                        else
                        begin
                            err_flag_next = 1'b1;
                        end
                    end
                end
                fmsp_pkg::PH_PERM:
                begin
                    if (pm.hit)
                    begin
                        perm_mask_next = s_perm | pm.bits;
                    end
                    else
                    begin
                        cur_mode_next = fmsp_pkg::apply_clause(s_cur, s_who, s_perm, s_op);
                        if (ch == fmsp_pkg::CH_COMMA)
                        begin
                            who_mask_next = 9'o000;
                        end
                        else if (op_c != fmsp_pkg::OP_NONE)
                        begin
                            op_kind_next   = op_c;
                            perm_mask_next = 9'o000;
                        end
                        else if (!is_nul)
                        begin
                            err_flag_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    cur_mode_next = s_cur;
                end
            endcase
            at_start_next = 1'b0;
            if (is_nul)
            begin
                if (s_start)
                begin
                    result.new_mode = 9'o000;
                    result.status   = 1'b0;
                end
                else if (octal_ok_next && octal_digits_next)
                begin
                    bad_oct = (octal_value_next > {1'b0, fmsp_pkg::ALL_BITS})
                              || (octal_neg_next && octal_value_next != 10'd0);
                    result.status   = bad_oct;
                    result.new_mode = bad_oct ? cur_mode_next : octal_value_next[8:0];
                end
                else
                begin
                    result.new_mode = cur_mode_next;
                    result.status   = err_flag_next;
                end
                cur_mode_next = result.new_mode;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            cur_mode_reg     <= 9'o000;
            who_mask_reg     <= 9'o000;
            perm_mask_reg    <= 9'o000;
            op_kind_reg      <= fmsp_pkg::OP_NONE;
            phase_reg        <= fmsp_pkg::PH_WHO;
            octal_value_reg  <= 10'd0;
            octal_ok_reg     <= 1'b1;
            octal_neg_reg    <= 1'b0;
            err_flag_reg     <= 1'b0;
            at_start_reg     <= 1'b1;
            octal_digits_reg <= 1'b0;
        end
        else
        begin
            if (!ch_stall)
            begin
                in_valid_reg <= ch_valid;
            end
            if (advance)
            begin
                cur_mode_reg     <= cur_mode_next;
                who_mask_reg     <= who_mask_next;
                perm_mask_reg    <= perm_mask_next;
                op_kind_reg      <= op_kind_next;
                phase_reg        <= phase_next;
                octal_value_reg  <= octal_value_next;
                octal_ok_reg     <= octal_ok_next;
                octal_neg_reg    <= octal_neg_next;
                err_flag_reg     <= err_flag_next;
                at_start_reg     <= at_start_next;
                octal_digits_reg <= octal_digits_next;
            end
            if (emit && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!mode_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ch_valid && !ch_stall)
        begin
            in_reg <= ch_data;
        end
        if (emit && advance)
        begin
            out_reg <= result;
        end
    end

    assign mode_valid = out_valid_reg;
    assign mode_data  = out_reg;

endmodule
